[hdl/tlc_pkg.sv]
// tlc_pkg: shared types, codes and helpers for the two-level lru cache hierarchy unit
// no dependencies; used by the set update unit, the top level and the bench
`default_nettype none
package tlc_pkg;

   localparam int MAX_WAYS = 16;
   localparam int AGE_W    = 4;

   localparam logic [1:0] OWNER_NONE = 2'd0;
   localparam logic [1:0] OWNER_I    = 2'd1;
   localparam logic [1:0] OWNER_D    = 2'd2;

   localparam logic [2:0] REG_BLOCK_OFFSET = 3'd0;
   localparam logic [2:0] REG_I_LAT        = 3'd1;
   localparam logic [2:0] REG_D_LAT        = 3'd2;
   localparam logic [2:0] REG_L2_LAT       = 3'd3;
   localparam logic [2:0] REG_MEM_LAT      = 3'd4;
   localparam logic [2:0] REG_INCLUSIVE    = 3'd5;
   localparam logic [2:0] REG_LEVELS       = 3'd6;

   typedef enum logic {
      OP_ACCESS,
      OP_INVALIDATE
   } op_type;

   typedef struct packed {
      logic             valid;
      logic [31:0]      block;
      logic [AGE_W-1:0] age;
      logic [1:0]       owner;
   } way_type;

   localparam int WAY_W = $bits(way_type);

   typedef way_type [MAX_WAYS-1:0] set_row_type;

   typedef struct packed {
      op_type      op;
      logic [4:0]  n_ways;
      logic [31:0] block;
      logic [1:0]  owner;
   } su_cmd_type;

   typedef struct packed {
      logic        hit;
      logic        ev_valid;
      logic [31:0] ev_block;
      logic [1:0]  ev_owner;
   } su_result_type;

   // low ceil(log2(sets)) bits of the block, folded once into range
   function automatic logic [15:0] set_index(logic [31:0] blk, int sets, int bits);
      logic [32:0] m;
      m = {1'b0, blk} & ((33'd1 << bits) - 33'd1);
      if (m >= 33'(sets)) m = m - 33'(sets);
      return m[15:0];
   endfunction

endpackage
`default_nettype wire

[hdl/tlc_if.sv]
// tlc_req_if, tlc_rsp_if, tlc_csr_if: valid/ready channels of the cache hierarchy unit
// no dependencies
`default_nettype none
interface tlc_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] address;
   modport source (output valid, kind, address, input ready);
   modport sink   (input valid, kind, address, output ready);
endinterface

interface tlc_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] access_time;
   logic        l1_hit;
   logic        l2_accessed;
   logic        l2_hit;
   modport source (output valid, access_time, l1_hit, l2_accessed, l2_hit, input ready);
   modport sink   (input valid, access_time, l1_hit, l2_accessed, l2_hit, output ready);
endinterface

interface tlc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [11:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/two_level_lru_cache_hierarchy_unit.sv]
// two_level_lru_cache_hierarchy_unit: tag-only i/d l1 over unified l2, true lru
// depends on tlc_pkg, tlc_if interfaces, tlc_ram, tlc_set_unit
//
//  channel   dir  handshake       payload
//  req_bus   in   valid/ready     kind, address
//  rsp_bus   out  valid/ready     access_time, l1_hit, l2_accessed, l2_hit
//  csr_bus   in   valid/ready     index, data (always ready)
//
// an access goes from accept through an l1 step, then, with l2 on, an l2 step on an
// l1 miss or with the l1 off, then a back-invalidation step when one is due, to the
// result (straight there with both levels off); each step is a set read then a pass
// through the single shared set update unit and a row write back.
// after reset a clearing pass over max(I_SETS, D_SETS, L2_SETS) set addresses zeroes all
// tag rams; no transaction is accepted meanwhile. a stalled result holds the block.
`default_nettype none
module two_level_lru_cache_hierarchy_unit #(
   parameter int I_SETS  = 256,
   parameter int I_WAYS  = 2,
   parameter int D_SETS  = 256,
   parameter int D_WAYS  = 2,
   parameter int L2_SETS = 512,
   parameter int L2_WAYS = 8
) (
   input wire logic  clock,
   input wire logic  reset,
   tlc_req_if.sink   req_bus,
   tlc_rsp_if.source rsp_bus,
   tlc_csr_if.sink   csr_bus
);
   localparam int IB  = $clog2(I_SETS);
   localparam int DB  = $clog2(D_SETS);
   localparam int LB  = $clog2(L2_SETS);
   localparam int IAW = I_SETS > 1 ? IB : 1;
   localparam int DAW = D_SETS > 1 ? DB : 1;
   localparam int LAW = L2_SETS > 1 ? LB : 1;
   localparam int MAX_SETS = (I_SETS > D_SETS ? (I_SETS > L2_SETS ? I_SETS : L2_SETS)
                                              : (D_SETS > L2_SETS ? D_SETS : L2_SETS));
   localparam int CW  = $clog2(MAX_SETS + 1);
   localparam int IRW = I_WAYS * tlc_pkg::WAY_W;
   localparam int DRW = D_WAYS * tlc_pkg::WAY_W;
   localparam int LRW = L2_WAYS * tlc_pkg::WAY_W;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_L1_RD, S_L1_UPD, S_L2_RD, S_L2_UPD, S_BI_RD, S_BI_UPD, S_RESP
   } state_type;

   // configuration
   logic [4:0]  off_ff;
   logic [7:0]  ilat_ff, dlat_ff, l2lat_ff;
   logic [11:0] mem_ff;
   logic        incl_ff;
   logic [2:0]  lev_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff   <= 5'd6;
         ilat_ff  <= 8'd1;
         dlat_ff  <= 8'd1;
         l2lat_ff <= 8'd10;
         mem_ff   <= 12'd100;
         incl_ff  <= 1'b0;
         lev_ff   <= 3'd7;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            tlc_pkg::REG_BLOCK_OFFSET: off_ff   <= csr_bus.data[4:0];
            tlc_pkg::REG_I_LAT:        ilat_ff  <= csr_bus.data[7:0];
            tlc_pkg::REG_D_LAT:        dlat_ff  <= csr_bus.data[7:0];
            tlc_pkg::REG_L2_LAT:       l2lat_ff <= csr_bus.data[7:0];
            tlc_pkg::REG_MEM_LAT:      mem_ff   <= csr_bus.data;
            tlc_pkg::REG_INCLUSIVE:    incl_ff  <= csr_bus.data[0];
            tlc_pkg::REG_LEVELS:       lev_ff   <= csr_bus.data[2:0];
            default: ;
         endcase
      end
   end

   // sequencer registers
   state_type    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic         kind_ff, kind_in;
   logic [31:0]  blk_ff, blk_in;
   logic         l2on_ff, l2on_in;
   logic [IAW-1:0] ia_ff, ia_in;
   logic [DAW-1:0] da_ff, da_in;
   logic [LAW-1:0] la_ff, la_in;
   logic         bid_ff, bid_in;
   logic [12:0]  time_ff, time_in;
   logic         l1hit_ff, l1hit_in, l2acc_ff, l2acc_in, l2hit_ff, l2hit_in;

   // rams
   logic [IRW-1:0] i_rd, i_wd;
   logic [DRW-1:0] d_rd, d_wd;
   logic [LRW-1:0] l_rd, l_wd;
   logic           i_we, d_we, l_we, clr;

   tlc_ram #(.WIDTH(IRW), .DEPTH(I_SETS)) u_iram (
      .clock(clock), .we(i_we), .waddr(clr ? cnt_ff[IAW-1:0] : ia_ff), .wdata(i_wd),
      .raddr(ia_ff), .rdata(i_rd));
   tlc_ram #(.WIDTH(DRW), .DEPTH(D_SETS)) u_dram (
      .clock(clock), .we(d_we), .waddr(clr ? cnt_ff[DAW-1:0] : da_ff), .wdata(d_wd),
      .raddr(da_ff), .rdata(d_rd));
   tlc_ram #(.WIDTH(LRW), .DEPTH(L2_SETS)) u_l2ram (
      .clock(clock), .we(l_we), .waddr(clr ? cnt_ff[LAW-1:0] : la_ff), .wdata(l_wd),
      .raddr(la_ff), .rdata(l_rd));

   // shared set unit
   tlc_pkg::su_cmd_type    cmd;
   tlc_pkg::set_row_type   row_in, row_out;
   tlc_pkg::su_result_type res;
   logic                   use_l2, use_d;

   tlc_set_unit u_set (.cmd(cmd), .row_in(row_in), .row_out(row_out), .res(res));

   always_comb begin
      clr    = (state_ff == S_CLEAR);
      use_l2 = (state_ff == S_L2_UPD);
      use_d  = (state_ff == S_BI_UPD) ? bid_ff : kind_ff;
      row_in = '0;
      if (use_l2) begin
         for (int w = 0; w < L2_WAYS; w++)
            row_in[w] = l_rd[w*tlc_pkg::WAY_W +: tlc_pkg::WAY_W];
      end else if (use_d) begin
         for (int w = 0; w < D_WAYS; w++)
            row_in[w] = d_rd[w*tlc_pkg::WAY_W +: tlc_pkg::WAY_W];
      end else begin
         for (int w = 0; w < I_WAYS; w++)
            row_in[w] = i_rd[w*tlc_pkg::WAY_W +: tlc_pkg::WAY_W];
      end
      cmd.op     = (state_ff == S_BI_UPD) ? tlc_pkg::OP_INVALIDATE : tlc_pkg::OP_ACCESS;
      cmd.n_ways = use_l2 ? 5'(L2_WAYS) : (use_d ? 5'(D_WAYS) : 5'(I_WAYS));
      cmd.block  = blk_ff;
      cmd.owner  = kind_ff ? tlc_pkg::OWNER_D : tlc_pkg::OWNER_I;

      for (int w = 0; w < I_WAYS; w++)
         i_wd[w*tlc_pkg::WAY_W +: tlc_pkg::WAY_W] = clr ? '0 : row_out[w];
      for (int w = 0; w < D_WAYS; w++)
         d_wd[w*tlc_pkg::WAY_W +: tlc_pkg::WAY_W] = clr ? '0 : row_out[w];
      for (int w = 0; w < L2_WAYS; w++)
         l_wd[w*tlc_pkg::WAY_W +: tlc_pkg::WAY_W] = clr ? '0 : row_out[w];

      i_we = (clr && cnt_ff < CW'(I_SETS)) ||
             (state_ff == S_L1_UPD && !kind_ff) || (state_ff == S_BI_UPD && !bid_ff);
      d_we = (clr && cnt_ff < CW'(D_SETS)) ||
             (state_ff == S_L1_UPD && kind_ff) || (state_ff == S_BI_UPD && bid_ff);
      l_we = (clr && cnt_ff < CW'(L2_SETS)) || use_l2;
   end

   // next state
   logic [31:0] req_blk;
   logic        l1on;

   assign req_bus.ready = (state_ff == S_IDLE);

   always_comb begin
      req_blk  = req_bus.address >> off_ff;
      l1on     = lev_ff[req_bus.kind];
      state_in = state_ff;
      cnt_in   = cnt_ff;
      kind_in  = kind_ff;
      blk_in   = blk_ff;
      l2on_in  = l2on_ff;
      ia_in    = ia_ff;
      da_in    = da_ff;
      la_in    = la_ff;
      bid_in   = bid_ff;
      time_in  = time_ff;
      l1hit_in = l1hit_ff;
      l2acc_in = l2acc_ff;
      l2hit_in = l2hit_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(MAX_SETS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               kind_in  = req_bus.kind;
               blk_in   = req_blk;
               l2on_in  = lev_ff[2];
               ia_in    = IAW'(tlc_pkg::set_index(req_blk, I_SETS, IB));
               da_in    = DAW'(tlc_pkg::set_index(req_blk, D_SETS, DB));
               la_in    = LAW'(tlc_pkg::set_index(req_blk, L2_SETS, LB));
               l1hit_in = 1'b0;
               l2acc_in = 1'b0;
               l2hit_in = 1'b0;
               time_in  = l1on ? 13'(req_bus.kind ? dlat_ff : ilat_ff) : '0;
               if (l1on) state_in = S_L1_RD;
               else if (lev_ff[2]) state_in = S_L2_RD;
               else begin
                  time_in  = 13'(mem_ff);
                  state_in = S_RESP;
               end
            end
         end
         S_L1_RD: state_in = S_L1_UPD;
         S_L1_UPD: begin
            if (res.hit) begin
               l1hit_in = 1'b1;
               state_in = S_RESP;
            end else if (l2on_ff) state_in = S_L2_RD;
            else begin
               time_in  = time_ff + 13'(mem_ff);
               state_in = S_RESP;
            end
         end
         S_L2_RD: state_in = S_L2_UPD;
         S_L2_UPD: begin
            l2acc_in = 1'b1;
            l2hit_in = res.hit;
            time_in  = res.hit ? time_ff + 13'(l2lat_ff)
                               : time_ff + 13'(l2lat_ff) + 13'(mem_ff);
            state_in = S_RESP;
            // inclusive eviction: remove the evicted block from the l1 recorded as its owner
            if (res.ev_valid && incl_ff &&
                (res.ev_owner == tlc_pkg::OWNER_I || res.ev_owner == tlc_pkg::OWNER_D)) begin
               bid_in   = (res.ev_owner == tlc_pkg::OWNER_D);
               blk_in   = res.ev_block;
               ia_in    = IAW'(tlc_pkg::set_index(res.ev_block, I_SETS, IB));
               da_in    = DAW'(tlc_pkg::set_index(res.ev_block, D_SETS, DB));
               state_in = S_BI_RD;
            end
         end
         S_BI_RD:  state_in = S_BI_UPD;
         S_BI_UPD: state_in = S_RESP;
         S_RESP: if (rsp_bus.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      kind_ff  <= kind_in;
      blk_ff   <= blk_in;
      l2on_ff  <= l2on_in;
      ia_ff    <= clr ? cnt_ff[IAW-1:0] : ia_in;
      da_ff    <= clr ? cnt_ff[DAW-1:0] : da_in;
      la_ff    <= clr ? cnt_ff[LAW-1:0] : la_in;
      bid_ff   <= bid_in;
      time_ff  <= time_in;
      l1hit_ff <= l1hit_in;
      l2acc_ff <= l2acc_in;
      l2hit_ff <= l2hit_in;
   end

   assign rsp_bus.valid       = (state_ff == S_RESP);
   assign rsp_bus.access_time = time_ff;
   assign rsp_bus.l1_hit      = l1hit_ff;
   assign rsp_bus.l2_accessed = l2acc_ff;
   assign rsp_bus.l2_hit      = l2hit_ff;
endmodule
`default_nettype wire

[hdl/tlc_ram.sv]
// tlc_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module tlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                      wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

[hdl/tlc_set_unit.sv]
// tlc_set_unit: shared lookup / lru update / fill / invalidate on one set row
// depends on tlc_pkg
`default_nettype none
module tlc_set_unit (
   input  wire tlc_pkg::su_cmd_type    cmd,
   input  wire tlc_pkg::set_row_type   row_in,
   output tlc_pkg::set_row_type        row_out,
   output tlc_pkg::su_result_type      res
);
   logic [tlc_pkg::MAX_WAYS-1:0] exists, match, free;
   logic [3:0]                   hit_way, free_way, old_way, tgt;
   logic                         hit, any_free;
   logic [tlc_pkg::AGE_W-1:0]    oldest, a;
   logic                         tgt_was_valid;

   always_comb begin
      oldest = tlc_pkg::AGE_W'(cmd.n_ways - 5'd1);
      hit_way  = '0;
      free_way = '0;
      old_way  = '0;
      for (int w = 0; w < tlc_pkg::MAX_WAYS; w++) begin
         exists[w] = (5'(w) < cmd.n_ways);
         match[w]  = exists[w] && row_in[w].valid && (row_in[w].block == cmd.block);
         free[w]   = exists[w] && !row_in[w].valid;
      end
      // lowest matching / lowest free way wins
      for (int w = tlc_pkg::MAX_WAYS - 1; w >= 0; w--) begin
         if (match[w]) hit_way = 4'(w);
         if (free[w]) free_way = 4'(w);
         if (exists[w] && row_in[w].valid && row_in[w].age == oldest) old_way = 4'(w);
      end
      hit      = |match;
      any_free = |free;
      if (hit) tgt = hit_way;
      else if (any_free) tgt = free_way;
      else tgt = old_way;
      if (cmd.op == tlc_pkg::OP_INVALIDATE) tgt = hit_way;
      tgt_was_valid = row_in[tgt].valid;
      a = row_in[tgt].age;

      row_out = row_in;
      res.hit      = hit;
      res.ev_valid = 1'b0;
      res.ev_block = row_in[tgt].block;
      res.ev_owner = row_in[tgt].owner;
      unique case (cmd.op)
         tlc_pkg::OP_ACCESS: begin
            res.ev_valid = !hit && !any_free;
            for (int w = 0; w < tlc_pkg::MAX_WAYS; w++) begin
               if (4'(w) != tgt && exists[w] && row_in[w].valid &&
                   (!tgt_was_valid || row_in[w].age < a))
                  row_out[w].age = row_in[w].age + 1'b1;
            end
            row_out[tgt].valid = 1'b1;
            row_out[tgt].block = cmd.block;
            row_out[tgt].age   = '0;
            row_out[tgt].owner = cmd.owner;
         end
         tlc_pkg::OP_INVALIDATE: begin
            if (hit) begin
               for (int w = 0; w < tlc_pkg::MAX_WAYS; w++) begin
                  if (exists[w] && row_in[w].valid && row_in[w].age > a)
                     row_out[w].age = row_in[w].age - 1'b1;
               end
               row_out[tgt] = '0;
            end
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

[bench/tb_two_level_lru_cache_hierarchy_unit.sv]
// tb_two_level_lru_cache_hierarchy_unit: self-checking bench for the i/d l1 over l2 lru hierarchy
// depends on tlc_pkg, the tlc_if interfaces and two_level_lru_cache_hierarchy_unit
// keeps its own tag model, predicts each access result and compares every response
`default_nettype none
module tb_two_level_lru_cache_hierarchy_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NI_SETS = 256, NI_WAYS = 2, ND_SETS = 256, ND_WAYS = 2;
   localparam int NL2_SETS = 512, NL2_WAYS = 8;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [12:0] access_time;
      logic        l1_hit;
      logic        l2_accessed;
      logic        l2_hit;
   } access_result_type;

   typedef struct {
      bit          valid;
      logic [31:0] block;
      int          age;
   } tag_line_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tlc_req_if req_bus ();
   tlc_rsp_if rsp_bus ();
   tlc_csr_if csr_bus ();

   two_level_lru_cache_hierarchy_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source),
      .csr_bus(csr_bus.sink)
   );

   // tag model state
   tag_line_type itags[];
   tag_line_type dtags[];
   tag_line_type l2tags[];
   logic [1:0] l2_owner[NL2_SETS*NL2_WAYS];
   logic [4:0]  cfg_offset;
   logic [7:0]  cfg_ilat, cfg_dlat, cfg_l2lat;
   logic [11:0] cfg_memlat;
   logic        cfg_incl;
   logic [2:0]  cfg_levels;

   access_result_type expected_results[$];
   int  mismatch_count = 0;
   bit  timed_out = 1'b0;
   bit  rsp_idle_enable = 1'b1;
   bit  req_idle_enable = 1'b1;
   int  rsp_hold_cycles = 0;
   bit  long_hold = 1'b0;
   event hold_off_ev;
   longint cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int set_base_of(logic [31:0] blk, int sets, int ways);
      int nbits;
      longint idx;
      nbits = $clog2(sets);
      idx = longint'(blk) & ((longint'(1) << nbits) - 1);
      return int'(idx % sets) * ways;
   endfunction

   function automatic int find_line(ref tag_line_type arr[], input int base, int ways,
                                    logic [31:0] blk);
      for (int w = 0; w < ways; w++)
         if (arr[base+w].valid && arr[base+w].block == blk) return w;
      return -1;
   endfunction

   function automatic void make_mru(ref tag_line_type arr[], input int base, int ways,
                                    int way);
      int a;
      a = arr[base+way].age;
      for (int w = 0; w < ways; w++)
         if (w != way && arr[base+w].valid && arr[base+w].age < a)
            arr[base+w].age++;
      arr[base+way].age = 0;
   endfunction

   // returns the way filled; ev_valid/ev_block report a displaced line
   function automatic int fill_line(ref tag_line_type arr[], input int base, int ways,
                                    logic [31:0] blk, output bit ev_valid,
                                    output logic [31:0] ev_block);
      int victim;
      victim = ways;
      for (int w = 0; w < ways && victim == ways; w++)
         if (!arr[base+w].valid) victim = w;
      ev_valid = 1'b0;
      ev_block = '0;
      if (victim == ways) begin
         victim = 0;
         for (int w = 1; w < ways; w++)
            if (arr[base+w].age > arr[base+victim].age) victim = w;
         ev_valid = 1'b1;
         ev_block = arr[base+victim].block;
         make_mru(arr, base, ways, victim);
      end else begin
         for (int w = 0; w < ways; w++)
            if (arr[base+w].valid) arr[base+w].age++;
         arr[base+victim].age = 0;
      end
      arr[base+victim].valid = 1'b1;
      arr[base+victim].block = blk;
      return victim;
   endfunction

   function automatic void drop_line(ref tag_line_type arr[], input int base, int ways,
                                     logic [31:0] blk);
      int f;
      f = find_line(arr, base, ways, blk);
      if (f < 0) return;
      for (int w = 0; w < ways; w++)
         if (arr[base+w].valid && arr[base+w].age > arr[base+f].age)
            arr[base+w].age--;
      arr[base+f].valid = 1'b0;
      arr[base+f].age = 0;
      arr[base+f].block = '0;
   endfunction

   function automatic bit l1_lookup(ref tag_line_type arr[], input int sets, int ways,
                                    logic [31:0] blk);
      int base, f;
      bit evv;
      logic [31:0] evb;
      base = set_base_of(blk, sets, ways);
      f = find_line(arr, base, ways, blk);
      if (f >= 0) begin
         make_mru(arr, base, ways, f);
         return 1'b1;
      end
      void'(fill_line(arr, base, ways, blk, evv, evb));
      return 1'b0;
   endfunction

   function automatic int l2_lookup(logic [31:0] blk, logic kind,
                                    inout logic l2acc, inout logic l2hit);
      int base, f, wo;
      bit evv;
      logic [31:0] evb;
      logic [1:0] who;
      if (!cfg_levels[2]) return int'(cfg_memlat);
      l2acc = 1'b1;
      base = set_base_of(blk, NL2_SETS, NL2_WAYS);
      f = find_line(l2tags, base, NL2_WAYS, blk);
      if (f >= 0) begin
         make_mru(l2tags, base, NL2_WAYS, f);
         l2_owner[base+f] = kind ? tlc_pkg::OWNER_D : tlc_pkg::OWNER_I;
         l2hit = 1'b1;
         return int'(cfg_l2lat);
      end
      wo = fill_line(l2tags, base, NL2_WAYS, blk, evv, evb);
      if (evv && cfg_incl) begin
         who = l2_owner[base+wo];
         if (who == tlc_pkg::OWNER_I)
            drop_line(itags, set_base_of(evb, NI_SETS, NI_WAYS), NI_WAYS, evb);
         else if (who == tlc_pkg::OWNER_D)
            drop_line(dtags, set_base_of(evb, ND_SETS, ND_WAYS), ND_WAYS, evb);
      end
      l2_owner[base+wo] = kind ? tlc_pkg::OWNER_D : tlc_pkg::OWNER_I;
      return int'(cfg_memlat) + int'(cfg_l2lat);
   endfunction

   function automatic access_result_type predict_access(logic kind, logic [31:0] addr);
      access_result_type r;
      logic [31:0] blk;
      int t;
      bit hit;
      logic acc, l2h;
      blk = addr >> cfg_offset;
      acc = 1'b0;
      l2h = 1'b0;
      r = '0;
      if (cfg_levels[kind]) begin
         hit = kind ? l1_lookup(dtags, ND_SETS, ND_WAYS, blk)
                    : l1_lookup(itags, NI_SETS, NI_WAYS, blk);
         t = kind ? int'(cfg_dlat) : int'(cfg_ilat);
         if (hit) r.l1_hit = 1'b1;
         else t += l2_lookup(blk, kind, acc, l2h);
      end else begin
         t = l2_lookup(blk, kind, acc, l2h);
      end
      r.access_time = 13'(t);
      r.l2_accessed = acc;
      r.l2_hit = l2h;
      return r;
   endfunction

   function automatic void model_reset();
      itags = new[NI_SETS*NI_WAYS];
      dtags = new[ND_SETS*ND_WAYS];
      l2tags = new[NL2_SETS*NL2_WAYS];
      foreach (itags[i]) itags[i] = '{1'b0, '0, 0};
      foreach (dtags[i]) dtags[i] = '{1'b0, '0, 0};
      foreach (l2tags[i]) l2tags[i] = '{1'b0, '0, 0};
      foreach (l2_owner[i]) l2_owner[i] = tlc_pkg::OWNER_NONE;
      cfg_offset = 5'd6;
      cfg_ilat = 8'd1;
      cfg_dlat = 8'd1;
      cfg_l2lat = 8'd10;
      cfg_memlat = 12'd100;
      cfg_incl = 1'b0;
      cfg_levels = 3'd7;
   endfunction

   // long receiver hold-off, counted here
   initial begin
      forever begin
         @(hold_off_ev);
         long_hold <= 1'b1;
         repeat (300) @(posedge clock);
         long_hold <= 1'b0;
      end
   end

   // response side: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      int burst;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (long_hold) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles <= rsp_hold_cycles - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_idle_enable && $urandom_range(0, 7) == 0) begin
         burst = $urandom_range(1, 10);
         rsp_hold_cycles <= burst;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      access_result_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.access_time, rsp_bus.l1_hit, rsp_bus.l2_accessed, rsp_bus.l2_hit};
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: time=%0d l1=%b l2acc=%b l2hit=%b",
                        got.access_time, got.l1_hit, got.l2_accessed, got.l2_hit);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: expected time=%0d l1=%b l2acc=%b l2hit=%b,",
                            " got time=%0d l1=%b l2acc=%b l2hit=%b"},
                           want.access_time, want.l1_hit, want.l2_accessed, want.l2_hit,
                           got.access_time, got.l1_hit, got.l2_accessed, got.l2_hit);
            end
         end
      end
   end

   task automatic send_access(logic kind, logic [31:0] addr);
      int gap;
      if (req_idle_enable && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind <= kind;
      req_bus.address <= addr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_results.push_back(predict_access(kind, addr));
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [11:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      case (idx)
         tlc_pkg::REG_BLOCK_OFFSET: cfg_offset = value[4:0];
         tlc_pkg::REG_I_LAT:        cfg_ilat = value[7:0];
         tlc_pkg::REG_D_LAT:        cfg_dlat = value[7:0];
         tlc_pkg::REG_L2_LAT:       cfg_l2lat = value[7:0];
         tlc_pkg::REG_MEM_LAT:      cfg_memlat = value[11:0];
         tlc_pkg::REG_INCLUSIVE:    cfg_incl = value[0];
         tlc_pkg::REG_LEVELS:       cfg_levels = value[2:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_access(1'b0, 32'h0000_0000);
      send_access(1'b0, 32'h0000_0004);
      send_access(1'b1, 32'hFFFF_FFFF);
      send_access(1'b1, 32'hFFFF_FFC0);
      send_access(1'b0, 32'hFFFF_FFFF);
      // l1 conflict: three blocks in one 2-way set, then the first again
      send_access(1'b1, 32'h0001_0040);
      send_access(1'b1, 32'h0002_0040);
      send_access(1'b1, 32'h0003_0040);
      send_access(1'b1, 32'h0001_0040);
      send_access(1'b0, 32'hAAAA_5555);
      send_access(1'b0, 32'h5555_AAAA);
      wait_drained();
   endtask

   // lots of blocks into one l2 set with back-invalidation enabled
   task automatic test_inclusive_evictions();
      write_reg(tlc_pkg::REG_INCLUSIVE, 12'd1);
      write_reg(tlc_pkg::REG_MEM_LAT, 12'd4095);
      write_reg(tlc_pkg::REG_L2_LAT, 12'd255);
      write_reg(tlc_pkg::REG_I_LAT, 12'd255);
      write_reg(tlc_pkg::REG_D_LAT, 12'd255);
      for (int i = 0; i < 60; i++)
         send_access(1'($urandom_range(0, 1)),
                     (32'($urandom_range(0, 15)) << 15) | (32'd7 << 6));
      wait_drained();
   endtask

   task automatic test_levels_and_offsets();
      for (int lv = 0; lv < 8; lv++) begin
         write_reg(tlc_pkg::REG_LEVELS, 12'(lv));
         write_reg(tlc_pkg::REG_BLOCK_OFFSET, 12'($urandom_range(0, 16)));
         for (int i = 0; i < 15; i++)
            send_access(1'($urandom_range(0, 1)), $urandom_range(0, 4095) << 4);
         wait_drained();
      end
      write_reg(tlc_pkg::REG_BLOCK_OFFSET, 12'd0);
      write_reg(tlc_pkg::REG_I_LAT, 12'd0);
      write_reg(tlc_pkg::REG_D_LAT, 12'd0);
      write_reg(tlc_pkg::REG_L2_LAT, 12'd0);
      write_reg(tlc_pkg::REG_MEM_LAT, 12'd0);
      write_reg(tlc_pkg::REG_LEVELS, 12'd7);
      for (int i = 0; i < 15; i++) send_access(1'($urandom_range(0, 1)), $urandom);
      wait_drained();
      write_reg(tlc_pkg::REG_BLOCK_OFFSET, 12'd16);
      for (int i = 0; i < 10; i++) send_access(1'($urandom_range(0, 1)), $urandom);
      wait_drained();
   endtask

   // receiver holds off while the sender keeps pushing
   task automatic test_backpressure();
      -> hold_off_ev;
      for (int i = 0; i < 20; i++) send_access(1'($urandom_range(0, 1)), $urandom);
      wait_drained();
   endtask

   task automatic test_random(int count, bit no_idle);
      logic [31:0] hot[16];
      logic [31:0] addr;
      if (no_idle) begin
         req_idle_enable = 1'b0;
         rsp_idle_enable = 1'b0;
      end
      foreach (hot[i]) hot[i] = $urandom;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: addr = $urandom;
            1: addr = hot[$urandom_range(0, 15)] ^ $urandom_range(0, 63);
            default: addr = ($urandom_range(0, 31) << 15) | ($urandom_range(0, 3) << 6);
         endcase
         send_access(1'($urandom_range(0, 1)), addr);
         if (i % 150 == 149) begin
            wait_drained();
            write_reg(tlc_pkg::REG_INCLUSIVE, 12'($urandom_range(0, 1)));
            write_reg(tlc_pkg::REG_LEVELS, 12'($urandom_range(0, 7)));
            write_reg(tlc_pkg::REG_BLOCK_OFFSET, 12'($urandom_range(0, 8)));
            write_reg(tlc_pkg::REG_MEM_LAT, 12'($urandom_range(0, 4095)));
            write_reg(tlc_pkg::REG_L2_LAT, 12'($urandom_range(0, 255)));
            write_reg(tlc_pkg::REG_I_LAT, 12'($urandom_range(0, 255)));
            write_reg(tlc_pkg::REG_D_LAT, 12'($urandom_range(0, 255)));
         end
      end
      wait_drained();
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.kind = 1'b0;
      req_bus.address = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
      model_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_inclusive_evictions();
      test_levels_and_offsets();
      test_backpressure();
      write_reg(tlc_pkg::REG_LEVELS, 12'd7);
      write_reg(tlc_pkg::REG_BLOCK_OFFSET, 12'd6);
      test_random(360, 1'b0);
      test_random(150, 1'b1);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
